FILE: design/eln_pkg.sv
// Shared types and constants for the echo-wave leader election node.
package eln_pkg;

  localparam int unsigned NumPorts  = 6;
  localparam int unsigned IdW       = 16;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned PortW     = 3;
  localparam int unsigned PendW     = 3;
  localparam int unsigned CfgDataW  = 24;

  localparam logic [ColorW-1:0] ColWhite   = 24'hFFFFFF;
  localparam logic [ColorW-1:0] ColBlue    = 24'h0000FF;
  localparam logic [ColorW-1:0] ColMagenta = 24'hFF00FF;
  localparam logic [ColorW-1:0] ColCyan    = 24'h00FFFF;
  localparam logic [ColorW-1:0] ColRed     = 24'hFF0000;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_RETURN = 2'd2,
    ACT_COLOR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_RETURN = 2'd2,
    KIND_COLOR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_OWN_ID        = 2'd0,
    CFG_OWN_COLOR     = 2'd1,
    CFG_NEIGHBOR_MASK = 2'd2,
    CFG_STARTER_ID    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [IdW-1:0]      own_id;
    logic [ColorW-1:0]   own_color;
    logic [NumPorts-1:0] neighbor_mask;
    logic [IdW-1:0]      starter_id;
  } cfg_t;

  typedef struct packed {
    action_e             action;
    logic [PortW-1:0]    arrival_port;
    logic [IdW-1:0]      sender_id;
    logic [ColorW-1:0]   sender_color;
  } item_t;

  // One item's outgoing messages: a port set sharing kind and payload
  typedef struct packed {
    logic [NumPorts-1:0] port_mask;
    kind_e               kind;
    logic [IdW-1:0]      msg_id;
    logic [ColorW-1:0]   msg_color;
    logic [ColorW-1:0]   display_color;
  } plan_t;

endpackage

FILE: design/echo_leader_election_node_top.sv
// Top level of the echo-wave leader election node: config registers and datapath.
//
//  channel | handshake             | words
//  in      | in_valid_i/in_stall_o | action, arrival_port, sender_id, sender_color
//  out     | out_valid_o/out_stall_i | out_port, msg_kind, msg_id, msg_color,
//          |                       | display_color, last
//  cfg     | cfg_we_i              | cfg_idx_i selects, cfg_wdata_i carries value
//
// An input word produces one to six output words, with last on the final one; the
// output register emits one word a cycle while not stalled. The input register
// loads on the accepting edge; the first word then goes through the plan
// register, then the output register.
// Reset clears all control and election state; the shown color resets to white.
// A stall on the output holds the current word and backs up to in_stall_o.
module echo_leader_election_node_top #(
  parameter int unsigned PORT_COUNT = 6,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [eln_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [eln_pkg::PortW-1:0]      arrival_port_i,
  input  logic [eln_pkg::IdW-1:0]        sender_id_i,
  input  logic [eln_pkg::ColorW-1:0]     sender_color_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [eln_pkg::PortW-1:0]      out_port_o,
  output logic [1:0]                     msg_kind_o,
  output logic [eln_pkg::IdW-1:0]        msg_id_o,
  output logic [eln_pkg::ColorW-1:0]     msg_color_o,
  output logic [eln_pkg::ColorW-1:0]     display_color_o,
  output logic                           last_o
);
  import eln_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  plan_t plan;
  logic  plan_valid;
  logic  plan_ready;

  // write config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id        <= '0;
      cfg_q.own_color     <= '0;
      cfg_q.neighbor_mask <= '0;
      cfg_q.starter_id    <= IdW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_OWN_ID:        cfg_q.own_id        <= cfg_wdata_i[IdW-1:0];
        CFG_OWN_COLOR:     cfg_q.own_color     <= cfg_wdata_i[ColorW-1:0];
        CFG_NEIGHBOR_MASK: cfg_q.neighbor_mask <= cfg_wdata_i[NumPorts-1:0];
        CFG_STARTER_ID:    cfg_q.starter_id    <= cfg_wdata_i[IdW-1:0];
        default:           cfg_q.own_id        <= cfg_q.own_id;
      endcase
    end
  end

  // pack the input word
  always_comb begin
    item.action       = action_e'(action_i);
    item.arrival_port = arrival_port_i;
    item.sender_id    = sender_id_i;
    item.sender_color = sender_color_i;
  end

  eln_core #(
    .PORT_COUNT (PORT_COUNT),
    .ID_BITS    (ID_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (item),
    .plan_ready_i (plan_ready),
    .plan_valid_o (plan_valid),
    .plan_o       (plan)
  );

  eln_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .plan_valid_i    (plan_valid),
    .plan_ready_o    (plan_ready),
    .plan_i          (plan),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_port_o      (out_port_o),
    .msg_kind_o      (msg_kind_o),
    .msg_id_o        (msg_id_o),
    .msg_color_o     (msg_color_o),
    .display_color_o (display_color_o),
    .last_o          (last_o)
  );

endmodule

FILE: design/eln_core.sv
// Input register and election state update, producing one message plan per word.
module eln_core #(
  parameter int unsigned PORT_COUNT = 6,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  eln_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  eln_pkg::item_t item_i,
  input  logic           plan_ready_i,
  output logic           plan_valid_o,
  output eln_pkg::plan_t plan_o
);
  import eln_pkg::*;

  localparam int unsigned PortLim = (PORT_COUNT < NumPorts) ? PORT_COUNT : NumPorts;
  localparam int unsigned LidW    = (ID_BITS < IdW) ? ID_BITS : IdW;

  // input register
  logic  item_valid_q, item_valid_d;
  item_t item_q;
  logic  accept, fire;

  // election state
  logic [LidW-1:0]   leader_id_q, leader_id_d;
  logic [ColorW-1:0] leader_color_q, leader_color_d;
  logic              reached_q, reached_d;
  logic              has_parent_q, has_parent_d;
  logic [PortW-1:0]  parent_port_q, parent_port_d;
  logic [PendW-1:0]  pending_q, pending_d;
  logic              colored_q, colored_d;
  logic [ColorW-1:0] shown_q, shown_d;

  logic [NumPorts-1:0] port_lim_mask;
  logic [NumPorts-1:0] nb_mask;
  logic [NumPorts-1:0] arrival_hot;
  logic [NumPorts-1:0] fwd_mask;
  logic [NumPorts-1:0] send_mask;
  logic                port_ok;
  logic [LidW-1:0]     sid;
  logic [LidW-1:0]     adopt_id;
  logic [ColorW-1:0]   adopt_color;
  logic [PendW-1:0]    pend_dec;
  kind_e               send_kind;

  assign fire         = item_valid_q && plan_ready_i;
  assign in_stall_o   = item_valid_q && !plan_ready_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign plan_valid_o = fire;

  // hold a word until the plan stage frees up
  always_comb begin
    item_valid_d = item_valid_q;
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (fire) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  // usable ports and neighbors
  always_comb begin
    for (int p = 0; p < NumPorts; p++) begin
      port_lim_mask[p] = (p < PortLim);
    end
  end

  assign nb_mask     = cfg_i.neighbor_mask & port_lim_mask;
  assign port_ok     = ({1'b0, item_q.arrival_port} < (PortW + 1)'(PortLim));
  assign arrival_hot = NumPorts'(1) << item_q.arrival_port;
  assign fwd_mask    = nb_mask & ~arrival_hot;
  assign sid         = item_q.sender_id[LidW-1:0];
  assign adopt_id    = (leader_id_q < sid) ? sid : leader_id_q;
  assign adopt_color = (leader_id_q < sid) ? item_q.sender_color : leader_color_q;
  assign pend_dec    = pending_q - PendW'(1);

  // step the election state and build the message plan
  always_comb begin
    leader_id_d    = leader_id_q;
    leader_color_d = leader_color_q;
    reached_d      = reached_q;
    has_parent_d   = has_parent_q;
    parent_port_d  = parent_port_q;
    pending_d      = pending_q;
    colored_d      = colored_q;
    shown_d        = shown_q;
    send_mask      = '0;
    send_kind      = KIND_NONE;

    case (item_q.action)
      ACT_START: begin
        leader_id_d    = cfg_i.own_id[LidW-1:0];
        leader_color_d = cfg_i.own_color;
        reached_d      = 1'b0;
        has_parent_d   = 1'b0;
        parent_port_d  = '0;
        pending_d      = '0;
        colored_d      = 1'b0;
        shown_d        = ColWhite;
        if (cfg_i.own_id[LidW-1:0] == cfg_i.starter_id[LidW-1:0]) begin
          shown_d   = ColBlue;
          reached_d = 1'b1;
          send_mask = nb_mask;
          send_kind = KIND_SEARCH;
          pending_d = PendW'($countones(nb_mask));
        end
      end
      ACT_SEARCH: begin
        if (port_ok) begin
          leader_id_d    = adopt_id;
          leader_color_d = adopt_color;
          if (reached_q) begin
            send_mask = arrival_hot;
            send_kind = KIND_RETURN;
          end else begin
            reached_d     = 1'b1;
            parent_port_d = item_q.arrival_port;
            pending_d     = PendW'($countones(fwd_mask));
            if (fwd_mask == '0) begin
              // leaf: answer the new parent at once
              has_parent_d = 1'b0;
              shown_d      = ColCyan;
              send_mask    = arrival_hot;
              send_kind    = KIND_RETURN;
            end else begin
              has_parent_d = 1'b1;
              shown_d      = ColMagenta;
              send_mask    = fwd_mask;
              send_kind    = KIND_SEARCH;
            end
          end
        end
      end
      ACT_RETURN: begin
        if (port_ok) begin
          leader_id_d    = adopt_id;
          leader_color_d = adopt_color;
          if (pending_q != '0) begin
            pending_d = pend_dec;
            if (pend_dec == '0) begin
              if (has_parent_q) begin
                has_parent_d = 1'b0;
                shown_d      = adopt_color;
                send_mask    = NumPorts'(1) << parent_port_q;
                send_kind    = KIND_RETURN;
              end else begin
                shown_d   = ColRed;
                send_mask = nb_mask;
                send_kind = KIND_COLOR;
              end
            end
          end
        end
      end
      ACT_COLOR: begin
        if (port_ok) begin
          leader_color_d = item_q.sender_color;
          if (!colored_q) begin
            colored_d = 1'b1;
            shown_d   = item_q.sender_color;
            send_mask = fwd_mask;
            send_kind = KIND_COLOR;
          end
        end
      end
      default: begin
        send_kind = KIND_NONE;
      end
    endcase
  end

  // plan fields follow the updated leader
  always_comb begin
    plan_o.port_mask     = send_mask;
    plan_o.kind          = send_kind;
    plan_o.msg_id        = (send_kind == KIND_COLOR) ? '0 : IdW'(leader_id_d);
    plan_o.msg_color     = leader_color_d;
    plan_o.display_color = shown_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leader_id_q    <= '0;
      leader_color_q <= '0;
      reached_q      <= 1'b0;
      has_parent_q   <= 1'b0;
      parent_port_q  <= '0;
      pending_q      <= '0;
      colored_q      <= 1'b0;
      shown_q        <= ColWhite;
    end else if (fire) begin
      leader_id_q    <= leader_id_d;
      leader_color_q <= leader_color_d;
      reached_q      <= reached_d;
      has_parent_q   <= has_parent_d;
      parent_port_q  <= parent_port_d;
      pending_q      <= pending_d;
      colored_q      <= colored_d;
      shown_q        <= shown_d;
    end
  end

endmodule

FILE: design/eln_emit.sv
// Plan register and output register: one message word per port in the plan.
module eln_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        plan_valid_i,
  output logic                        plan_ready_o,
  input  eln_pkg::plan_t              plan_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [eln_pkg::PortW-1:0]   out_port_o,
  output logic [1:0]                  msg_kind_o,
  output logic [eln_pkg::IdW-1:0]     msg_id_o,
  output logic [eln_pkg::ColorW-1:0]  msg_color_o,
  output logic [eln_pkg::ColorW-1:0]  display_color_o,
  output logic                        last_o
);
  import eln_pkg::*;

  logic  plan_valid_q, plan_valid_d;
  plan_t plan_q;
  logic  out_valid_q, out_valid_d;

  logic [NumPorts-1:0] low_hot;
  logic [NumPorts-1:0] rest_mask;
  logic [PortW-1:0]    low_idx;
  logic                take;
  logic                plan_last;
  logic                no_msg;

  // pick the lowest pending port
  assign low_hot   = plan_q.port_mask & (~plan_q.port_mask + NumPorts'(1));
  assign rest_mask = plan_q.port_mask & ~low_hot;
  assign no_msg    = (plan_q.port_mask == '0);

  always_comb begin
    low_idx = '0;
    for (int p = 0; p < NumPorts; p++) begin
      if (low_hot[p]) begin
        low_idx = PortW'(p);
      end
    end
  end

  assign take         = plan_valid_q && (!out_valid_q || !out_stall_i);
  assign plan_last    = take && (rest_mask == '0);
  assign plan_ready_o = !plan_valid_q || plan_last;

  // advance the plan one port per word
  always_comb begin
    plan_valid_d = plan_valid_q;
    if (plan_valid_i) begin
      plan_valid_d = 1'b1;
    end else if (plan_last) begin
      plan_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      plan_valid_q <= plan_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (plan_valid_i) begin
      plan_q <= plan_i;
    end else if (take) begin
      plan_q.port_mask <= rest_mask;
    end
  end

  // load the output word; a plan without ports gives one empty word
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_port_o      <= no_msg ? '0 : low_idx;
      msg_kind_o      <= no_msg ? KIND_NONE : plan_q.kind;
      msg_id_o        <= no_msg ? '0 : plan_q.msg_id;
      msg_color_o     <= no_msg ? '0 : plan_q.msg_color;
      display_color_o <= plan_q.display_color;
      last_o          <= (rest_mask == '0);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/eln_checker.sv
// Port-level checks for the election node, bound to the top level.
module eln_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [eln_pkg::PortW-1:0]      out_port_o,
  input logic [1:0]                     msg_kind_o,
  input logic [eln_pkg::IdW-1:0]        msg_id_o,
  input logic [eln_pkg::ColorW-1:0]     msg_color_o,
  input logic                           last_o
);
  import eln_pkg::*;

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(msg_kind_o) && $stable(out_port_o)
      && $stable(msg_id_o) && $stable(last_o))
    else $error("stalled output word changed");

  // an empty word is alone and blank
  a_none_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (msg_kind_o == KIND_NONE) |->
      last_o && (out_port_o == '0) && (msg_id_o == '0) && (msg_color_o == '0))
    else $error("empty word not blank or not last");

  // a return goes to a single port, so it is the last word of its item
  a_return_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (msg_kind_o == KIND_RETURN) |-> last_o)
    else $error("return word not last of its item");

  // color floods carry no id
  a_color_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (msg_kind_o == KIND_COLOR) |-> (msg_id_o == '0))
    else $error("color word carries an id");

endmodule

bind echo_leader_election_node_top eln_checker u_eln_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_port_o  (out_port_o),
  .msg_kind_o  (msg_kind_o),
  .msg_id_o    (msg_id_o),
  .msg_color_o (msg_color_o),
  .last_o      (last_o)
);

FILE: tb/tb_echo_leader_election_node_top.sv
// Self-checking testbench for the echo-wave leader election node, with a built-in predictor.
module tb_echo_leader_election_node_top;
  timeunit 1ns;
  timeprecision 1ps;

  import eln_pkg::*;

  localparam int unsigned CycleLimit = 100000;

  // One outgoing message word as the node should send it
  typedef struct {
    logic [PortW-1:0]  port;
    kind_e             kind;
    logic [IdW-1:0]    id;
    logic [ColorW-1:0] color;
    logic [ColorW-1:0] shown;
    logic              last;
  } node_msg_t;

  // Clock, reset and block inputs, all known from time zero
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [1:0]          cfg_idx_i      = '0;
  logic [CfgDataW-1:0] cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic [1:0]          action_i       = '0;
  logic [PortW-1:0]    arrival_port_i = '0;
  logic [IdW-1:0]      sender_id_i    = '0;
  logic [ColorW-1:0]   sender_color_i = '0;
  logic                out_stall_i    = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [PortW-1:0]    out_port_o;
  logic [1:0]          msg_kind_o;
  logic [IdW-1:0]      msg_id_o;
  logic [ColorW-1:0]   msg_color_o;
  logic [ColorW-1:0]   display_color_o;
  logic                last_o;

  // Pending input words and the messages the node owes
  item_t     inbox_q[$];
  node_msg_t sent_msg_q[$];
  node_msg_t step_msgs[$];
  item_t     cur_word;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles         = 0;
  int unsigned errors         = 0;
  int unsigned n_queued       = 0;
  int unsigned n_accepted     = 0;
  int unsigned n_words        = 0;
  int unsigned n_cfg_writes   = 0;
  int unsigned n_waves        = 0;

  // Register copies
  logic [IdW-1:0]      reg_own_id;
  logic [ColorW-1:0]   reg_own_color;
  logic [NumPorts-1:0] reg_nbr_mask;
  logic [IdW-1:0]      reg_starter_id;

  // Election state of the node
  logic [IdW-1:0]    nd_leader_id;
  logic [ColorW-1:0] nd_leader_color;
  logic [ColorW-1:0] nd_shown;
  logic              nd_reached;
  logic              nd_has_parent;
  logic [PortW-1:0]  nd_parent_port;
  logic [PendW-1:0]  nd_pending;
  logic              nd_colored;

  echo_leader_election_node_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .arrival_port_i,
    .sender_id_i,
    .sender_color_i,
    .out_valid_o,
    .out_stall_i,
    .out_port_o,
    .msg_kind_o,
    .msg_id_o,
    .msg_color_o,
    .display_color_o,
    .last_o
  );

  always #6 clk_i = ~clk_i;

  // Queue one outgoing message, at most six per input word
  task automatic send_msg(input int unsigned port, input kind_e kind,
                          input logic [IdW-1:0] id, input logic [ColorW-1:0] color);
    node_msg_t m;
    m.port  = PortW'(port);
    m.kind  = kind;
    m.id    = id;
    m.color = color;
    m.shown = '0;
    m.last  = 1'b0;
    if (step_msgs.size() < NumPorts) step_msgs.push_back(m);
  endtask

  // Send a search to every connected port but skip; skip of 8 means none
  task automatic flood_search(input int unsigned skip);
    int unsigned cnt;
    cnt = 0;
    nd_reached = 1'b1;
    for (int unsigned p = 0; p < NumPorts; p++) begin
      if (reg_nbr_mask[p] && p != skip) begin
        cnt++;
        send_msg(p, KIND_SEARCH, nd_leader_id, nd_leader_color);
      end
    end
    nd_pending = (cnt > 7) ? PendW'(7) : PendW'(cnt);
  endtask

  task automatic flood_color(input int unsigned skip);
    for (int unsigned p = 0; p < NumPorts; p++) begin
      if (reg_nbr_mask[p] && p != skip) send_msg(p, KIND_COLOR, '0, nd_leader_color);
    end
  endtask

  // All answers in: echo to the parent, or as root turn red and flood the color
  task automatic wave_done(input bit search_path);
    if (nd_has_parent) begin
      send_msg(nd_parent_port, KIND_RETURN, nd_leader_id, nd_leader_color);
      nd_has_parent = 1'b0;
      nd_shown = search_path ? ColCyan : nd_leader_color;
    end else begin
      nd_shown = ColRed;
      flood_color(8);
    end
  endtask

  task automatic adopt_leader(input logic [IdW-1:0] id, input logic [ColorW-1:0] color);
    if (nd_leader_id < id) begin
      nd_leader_id    = id;
      nd_leader_color = color;
    end
  endtask

  task automatic node_reset();
    reg_own_id      = '0;
    reg_own_color   = '0;
    reg_nbr_mask    = '0;
    reg_starter_id  = IdW'(1);
    nd_leader_id    = '0;
    nd_leader_color = '0;
    nd_shown        = ColWhite;
    nd_reached      = 1'b0;
    nd_has_parent   = 1'b0;
    nd_parent_port  = '0;
    nd_pending      = '0;
    nd_colored      = 1'b0;
  endtask

  // Advance the node by one input word and store the messages it must send
  task automatic elect_predict(input item_t w);
    step_msgs.delete();
    if (w.action == ACT_START) begin
      nd_leader_id    = reg_own_id;
      nd_leader_color = reg_own_color;
      nd_reached      = 1'b0;
      nd_has_parent   = 1'b0;
      nd_parent_port  = '0;
      nd_pending      = '0;
      nd_colored      = 1'b0;
      nd_shown        = ColWhite;
      if (reg_own_id == reg_starter_id) begin
        nd_shown = ColBlue;
        flood_search(8);
      end
    end else if (w.arrival_port < NumPorts) begin
      case (w.action)
        ACT_SEARCH: begin
          adopt_leader(w.sender_id, w.sender_color);
          if (nd_reached) begin
            send_msg(w.arrival_port, KIND_RETURN, nd_leader_id, nd_leader_color);
          end else begin
            nd_has_parent  = 1'b1;
            nd_parent_port = w.arrival_port;
            flood_search(w.arrival_port);
            nd_shown = ColMagenta;
            if (nd_pending == 0) wave_done(1'b1);
          end
        end
        ACT_RETURN: begin
          adopt_leader(w.sender_id, w.sender_color);
          if (nd_pending != 0) begin
            nd_pending--;
            if (nd_pending == 0) wave_done(1'b0);
          end
        end
        default: begin
          nd_leader_color = w.sender_color;
          if (!nd_colored) begin
            nd_colored = 1'b1;
            nd_shown   = nd_leader_color;
            flood_color(w.arrival_port);
          end
        end
      endcase
    end
    if (step_msgs.size() == 0) send_msg(0, KIND_NONE, '0, '0);
    foreach (step_msgs[k]) begin
      step_msgs[k].shown = nd_shown;
      step_msgs[k].last  = (k == step_msgs.size() - 1);
      sent_msg_q.push_back(step_msgs[k]);
    end
  endtask

  // Driver: present queued words, idle at random, hold while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        elect_predict(cur_word);
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (inbox_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = inbox_q.pop_front();
          in_valid_i     <= 1'b1;
          action_i       <= cur_word.action;
          arrival_port_i <= cur_word.arrival_port;
          sender_id_i    <= cur_word.sender_id;
          sender_color_i <= cur_word.sender_color;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic bit field_bad(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Monitor: compare each accepted word with the oldest owed message
  always @(posedge clk_i) begin : mon_blk
    node_msg_t want;
    bit        bad;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (sent_msg_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual port %0d kind %0d",
                   $time, out_port_o, msg_kind_o);
          errors++;
        end else begin
          want = sent_msg_q.pop_front();
          n_words++;
          bad = 1'b0;
          bad |= field_bad("out_port", want.port, out_port_o);
          bad |= field_bad("msg_kind", want.kind, msg_kind_o);
          bad |= field_bad("msg_id", want.id, msg_id_o);
          bad |= field_bad("msg_color", want.color, msg_color_o);
          bad |= field_bad("display_color", want.shown, display_color_o);
          bad |= field_bad("last", want.last, last_o);
          if (bad) errors++;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d messages still owed", cycles, sent_msg_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_OWN_ID:        reg_own_id     = val[IdW-1:0];
      CFG_OWN_COLOR:     reg_own_color  = val[ColorW-1:0];
      CFG_NEIGHBOR_MASK: reg_nbr_mask   = val[NumPorts-1:0];
      default:           reg_starter_id = val[IdW-1:0];
    endcase
    n_cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic push_item(input action_e act, input int unsigned port,
                           input logic [IdW-1:0] id, input logic [ColorW-1:0] color);
    item_t w;
    w.action       = act;
    w.arrival_port = PortW'(port);
    w.sender_id    = id;
    w.sender_color = color;
    inbox_q.push_back(w);
    n_queued++;
  endtask

  // Wait until everything sent has come back, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk_i);
    while (inbox_q.size() != 0 || in_valid_i || sent_msg_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic randomize_config();
    logic [IdW-1:0]      id;
    logic [NumPorts-1:0] mask;
    id = IdW'($urandom);
    case ($urandom_range(7))
      0, 1:    mask = '1;
      2:       mask = '0;
      default: mask = NumPorts'($urandom);
    endcase
    write_reg(CFG_OWN_ID, CfgDataW'(id));
    write_reg(CFG_OWN_COLOR, CfgDataW'($urandom));
    write_reg(CFG_NEIGHBOR_MASK, CfgDataW'(mask));
    write_reg(CFG_STARTER_ID, $urandom_range(1) ? CfgDataW'(id) : CfgDataW'(IdW'($urandom)));
  endtask

  // One well-formed wave: start, join by search, collect the answers, then color
  task automatic push_wave();
    int unsigned         parent;
    int unsigned         answers;
    logic [NumPorts-1:0] mask;
    mask = reg_nbr_mask;
    push_item(ACT_START, $urandom_range(7), IdW'($urandom), ColorW'($urandom));
    if (reg_own_id != reg_starter_id) begin
      parent = $urandom_range(NumPorts - 1);
      mask[parent] = 1'b0;
      push_item(ACT_SEARCH, parent, IdW'($urandom), ColorW'($urandom));
    end
    answers = $countones(mask);
    for (int unsigned i = 0; i < answers; i++) begin
      if ($urandom_range(3) == 0) begin
        push_item(ACT_SEARCH, $urandom_range(NumPorts - 1), IdW'($urandom), ColorW'($urandom));
      end
      push_item(ACT_RETURN, $urandom_range(NumPorts - 1), IdW'($urandom), ColorW'($urandom));
    end
    if ($urandom_range(2) == 0) begin
      push_item(ACT_RETURN, $urandom_range(NumPorts - 1), IdW'($urandom), ColorW'($urandom));
    end
    push_item(ACT_COLOR, $urandom_range(NumPorts - 1), IdW'($urandom), ColorW'($urandom));
    if ($urandom_range(1)) begin
      push_item(ACT_COLOR, $urandom_range(NumPorts - 1), IdW'($urandom), ColorW'($urandom));
    end
    n_waves++;
  endtask

  // Stimulus sequence
  initial begin
    int unsigned target;
    node_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Root of a full mesh: flood, echoes, red and color flood
    send_idle_pct  = 36;
    recv_stall_pct = 55;
    write_reg(CFG_OWN_ID, 24'h000005);
    write_reg(CFG_OWN_COLOR, 24'h123456);
    write_reg(CFG_NEIGHBOR_MASK, 24'h00003F);
    write_reg(CFG_STARTER_ID, 24'h000005);
    push_item(ACT_START, 7, '1, '1);
    push_item(ACT_SEARCH, 0, '1, '0);
    for (int unsigned p = 0; p < NumPorts; p++) begin
      push_item(ACT_RETURN, p, (p % 2) ? '1 : '0, ColorW'($urandom));
    end
    push_item(ACT_COLOR, 2, '0, '1);
    push_item(ACT_COLOR, 3, '1, '0);
    push_item(ACT_RETURN, 4, '1, '1);
    // Ports past the last one are ignored
    push_item(ACT_SEARCH, 6, '1, '1);
    push_item(ACT_RETURN, 7, '1, '1);
    push_item(ACT_COLOR, 6, '1, '1);
    push_item(ACT_START, 0, '0, '0);
    // Hold the sender until every owed message is out
    wait_drained();

    // Isolated follower answers at once; then the lonely starter
    write_reg(CFG_OWN_ID, 24'h000000);
    write_reg(CFG_OWN_COLOR, 24'h000000);
    write_reg(CFG_NEIGHBOR_MASK, 24'h000000);
    write_reg(CFG_STARTER_ID, 24'h00FFFF);
    push_item(ACT_START, 0, '0, '0);
    push_item(ACT_SEARCH, 5, '0, '0);
    push_item(ACT_SEARCH, 3, '1, '1);
    push_item(ACT_COLOR, 0, '0, 24'h00FF00);
    wait_drained();
    write_reg(CFG_STARTER_ID, 24'h000000);
    push_item(ACT_START, 1, '0, '0);
    wait_drained();

    // Follower on a two-port line
    write_reg(CFG_OWN_ID, 24'h00FFFF);
    write_reg(CFG_OWN_COLOR, 24'hFFFFFF);
    write_reg(CFG_NEIGHBOR_MASK, 24'h000021);
    push_item(ACT_START, 0, '0, '0);
    push_item(ACT_SEARCH, 0, IdW'(1), '0);
    push_item(ACT_RETURN, 5, '0, '0);
    push_item(ACT_COLOR, 5, '0, 24'h00FF00);
    wait_drained();

    // Random waves and noise under three idle profiles
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 36 : (phase == 1) ? 55 : 0;
      recv_stall_pct = (phase == 0) ? 55 : (phase == 1) ? 36 : 0;
      for (int c = 0; c < 3; c++) begin
        randomize_config();
        target = n_queued + 22;
        while (n_queued < target) begin
          if ($urandom_range(3) != 0) begin
            push_wave();
          end else begin
            push_item(action_e'($urandom_range(3)), $urandom_range(7),
                      IdW'($urandom), ColorW'($urandom));
          end
        end
        wait_drained();
      end
    end

    repeat (8) @(negedge clk_i);
    $display("run covered %0d input words in %0d waves and %0d register writes,", n_accepted,
             n_waves, n_cfg_writes);
    $display("checked %0d output words across three stall profiles", n_words);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
